// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the checker file of this block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK_ALL(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/lphm_pkg.sv =====
// Package for the linear probe hash map: sizes, hash constants, codes and types.
// No dependencies; used by every module of the block.
`default_nettype none

package lphm_pkg;

   localparam int TABLE_SLOTS  = 1024;
   localparam int KEY_BITS     = 32;
   localparam int DATA_BITS    = 32;
   localparam int IN_KEY_BITS  = 32;
   localparam int SLOT_BITS    = $clog2(TABLE_SLOTS);
   localparam int COUNT_BITS   = SLOT_BITS + 1;
   // An insert of a new key is refused once the count has reached this value.
   localparam int FULL_LIMIT   = TABLE_SLOTS * 3 / 4 - 1;

   // Depth of the command queue between front and back; a power of two.
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);

   localparam int HASH_SHIFT_A = 15;
   localparam int HASH_SHIFT_B = 13;
   localparam logic [KEY_BITS-1:0] HASH_MULT = KEY_BITS'(64'd2654435761);

   typedef enum logic [2:0] {
      STS_INSERTED = 3'd0,
      STS_KEPT     = 3'd1,
      STS_FULL     = 3'd2,
      STS_FOUND    = 3'd3,
      STS_MISS     = 3'd4,
      STS_ZERO     = 3'd5
   } status_type;

   typedef enum logic {
      ACT_INSERT = 1'b0,
      ACT_LOOKUP = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_PROBE
   } back_state_type;

   typedef struct packed {
      action_type             action;
      logic                   zero;
      logic [KEY_BITS-1:0]    key;
      logic [DATA_BITS-1:0]   value;
      logic [SLOT_BITS-1:0]   home;
   } cmd_type;

endpackage

`default_nettype wire

// ===== hw/rtl/lphm_front.sv =====
// Front end of the hash map: accepts request words, hashes the key in two stages
// and pushes a classified command into the queue. Depends on lphm_pkg.
`default_nettype none

module lphm_front import lphm_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   req_action,
   input  wire logic [IN_KEY_BITS-1:0] req_key,
   input  wire logic [DATA_BITS-1:0]   req_value,
   input  wire logic                   accept_en,
   input  wire logic                   q_full,
   output logic                        push,
   output cmd_type                     push_cmd
);

   logic                 s1_v_ff, s1_v_in;
   action_type           s1_action_ff;
   logic [KEY_BITS-1:0]  s1_key_ff;
   logic [DATA_BITS-1:0] s1_value_ff;
   logic [KEY_BITS-1:0]  s1_mix_ff;

   logic                 s2_v_ff, s2_v_in;
   action_type           s2_action_ff;
   logic [KEY_BITS-1:0]  s2_key_ff;
   logic [DATA_BITS-1:0] s2_value_ff;
   logic [KEY_BITS-1:0]  s2_prod_ff;

   logic                 s1_adv, s2_free, take;
   logic [KEY_BITS-1:0]  key_masked, mix_in, prod_in, hash_fin;

   assign push       = s2_v_ff && !q_full;
   assign s2_free    = !s2_v_ff || !q_full;
   assign s1_adv     = s1_v_ff && s2_free;
   assign req_ready  = (!s1_v_ff || s2_free) && accept_en;
   assign take       = req_valid && req_ready;

   // Bits above KEY_BITS are dropped before hashing and comparing.
   assign key_masked = KEY_BITS'(req_key);
   assign mix_in     = key_masked ^ (key_masked >> HASH_SHIFT_A);
   assign prod_in    = s1_mix_ff * HASH_MULT;
   assign hash_fin   = s2_prod_ff ^ (s2_prod_ff >> HASH_SHIFT_B);

   always_comb begin
      s1_v_in = s1_v_ff;
      if (take) begin
         s1_v_in = 1'b1;
      end else if (s1_adv) begin
         s1_v_in = 1'b0;
      end
      s2_v_in = s2_v_ff;
      if (s1_adv) begin
         s2_v_in = 1'b1;
      end else if (push) begin
         s2_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_action_ff <= action_type'(req_action);
         s1_key_ff    <= key_masked;
         s1_value_ff  <= req_value;
         s1_mix_ff    <= mix_in;
      end
      if (s1_adv) begin
         s2_action_ff <= s1_action_ff;
         s2_key_ff    <= s1_key_ff;
         s2_value_ff  <= s1_value_ff;
         s2_prod_ff   <= prod_in;
      end
   end

   always_comb begin
      push_cmd.action = s2_action_ff;
      push_cmd.zero   = (s2_key_ff == '0);
      push_cmd.key    = s2_key_ff;
      push_cmd.value  = s2_value_ff;
      push_cmd.home   = hash_fin[SLOT_BITS-1:0];
   end

endmodule

`default_nettype wire

// ===== hw/rtl/lphm_queue.sv =====
// Short command queue between the front and back parts of the hash map.
// Depends on lphm_pkg for the command type and depth.
`default_nettype none

module lphm_queue import lphm_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   output logic         full,
   input  wire logic    pop,
   output logic         q_valid,
   output cmd_type      q_cmd
);

   cmd_type              entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_BITS:0]   count_ff, count_in;

   assign full    = (count_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/lphm_back.sv =====
// Back end of the hash map: key and value memories, the probe sequencer, the
// clearing pass after reset and the result register. Depends on lphm_pkg.
`default_nettype none

module lphm_back import lphm_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 q_valid,
   input  wire cmd_type              q_cmd,
   output logic                      pop,
   output logic                      clear_done,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [2:0]                rsp_status,
   output logic [DATA_BITS-1:0]      rsp_value_out
);

   logic [KEY_BITS-1:0]  key_mem [TABLE_SLOTS];
   logic [DATA_BITS-1:0] val_mem [TABLE_SLOTS];

   back_state_type       state_ff, state_in;
   logic [SLOT_BITS-1:0] clr_cnt_ff, clr_cnt_in;
   logic [SLOT_BITS-1:0] probe_ff, probe_in;
   cmd_type              cmd_ff, cmd_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   logic [SLOT_BITS-1:0] rd_addr, wr_addr;
   logic [KEY_BITS-1:0]  key_rd_ff, wr_key;
   logic [DATA_BITS-1:0] val_rd_ff;
   logic                 key_we, val_we;

   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [DATA_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic                 rsp_load;

   logic                 out_free, slot_empty, slot_hit, is_full;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign slot_empty = (key_rd_ff == '0);
   assign slot_hit   = (key_rd_ff == cmd_ff.key);
   assign is_full    = (count_ff >= COUNT_BITS'(FULL_LIMIT));
   assign clear_done = (state_ff != BK_CLEAR);

   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      probe_in      = probe_ff;
      cmd_in        = cmd_ff;
      count_in      = count_ff;
      rd_addr       = probe_ff;
      wr_addr       = probe_ff;
      wr_key        = cmd_ff.key;
      key_we        = 1'b0;
      val_we        = 1'b0;
      pop           = 1'b0;
      rsp_load      = 1'b0;
      rsp_status_in = STS_ZERO;
      rsp_value_in  = '0;
      case (state_ff)
         BK_CLEAR: begin
            wr_addr    = clr_cnt_ff;
            wr_key     = '0;
            key_we     = 1'b1;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == SLOT_BITS'(TABLE_SLOTS - 1)) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (q_valid) begin
               if (q_cmd.zero) begin
                  if (out_free) begin
                     pop           = 1'b1;
                     rsp_load      = 1'b1;
                     rsp_status_in = STS_ZERO;
                  end
               end else begin
                  pop      = 1'b1;
                  cmd_in   = q_cmd;
                  rd_addr  = q_cmd.home;
                  probe_in = q_cmd.home;
                  state_in = BK_PROBE;
               end
            end
         end
         BK_PROBE: begin
            // The slot at probe_ff is on the read port now; the load stays
            // below full, so an empty slot always ends the walk.
            if (slot_empty || slot_hit) begin
               if (out_free) begin
                  rsp_load = 1'b1;
                  state_in = BK_IDLE;
                  if (cmd_ff.action == ACT_LOOKUP) begin
                     if (slot_hit) begin
                        rsp_status_in = STS_FOUND;
                        rsp_value_in  = val_rd_ff;
                     end else begin
                        rsp_status_in = STS_MISS;
                     end
                  end else if (slot_hit) begin
                     rsp_status_in = STS_KEPT;
                  end else if (is_full) begin
                     rsp_status_in = STS_FULL;
                  end else begin
                     rsp_status_in = STS_INSERTED;
                     key_we        = 1'b1;
                     val_we        = 1'b1;
                     count_in      = count_ff + 1'b1;
                  end
               end
            end else begin
               rd_addr  = probe_ff + 1'b1;
               probe_in = probe_ff + 1'b1;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_cnt_ff   <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      probe_ff <= probe_in;
      cmd_ff   <= cmd_in;
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_value_ff  <= rsp_value_in;
      end
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[wr_addr] <= wr_key;
      end
      key_rd_ff <= key_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (val_we) begin
         val_mem[wr_addr] <= cmd_ff.value;
      end
      val_rd_ff <= val_mem[rd_addr];
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_value_out = rsp_value_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/linear_probe_hash_map_top.sv =====
// Top level of the linear probe hash map: front, command queue and back.
// Depends on lphm_pkg, lphm_front, lphm_queue and lphm_back.
//
//   Channel  Ports                                  Direction  Word
//   req      req_valid/ready, action, key, value    in         one request
//   rsp      rsp_valid/ready, status, value_out     out        one result
//
// The front hashes a key in two registered stages and overlaps with the back.
// The back spends a dispatch step in its idle state and then probes one slot at a time,
// as the key memory has a single read port; a zero key takes the dispatch step only.
// After reset a clearing pass writes all 1024 key slots, one a cycle, with
// req_ready low until the pass is done.
// A stalled result holds the back; the queue and front keep taking words until they fill.
`default_nettype none

module linear_probe_hash_map_top import lphm_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   req_action,
   input  wire logic [IN_KEY_BITS-1:0] req_key,
   input  wire logic [DATA_BITS-1:0]   req_value,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [2:0]                  rsp_status,
   output logic [DATA_BITS-1:0]        rsp_value_out
);

   logic    push, q_full, q_valid, pop, clear_done;
   cmd_type push_cmd, q_cmd;

   lphm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .req_key    (req_key),
      .req_value  (req_value),
      .accept_en  (clear_done),
      .q_full     (q_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   lphm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (pop),
      .q_valid  (q_valid),
      .q_cmd    (q_cmd)
   );

   lphm_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_cmd         (q_cmd),
      .pop           (pop),
      .clear_done    (clear_done),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_value_out (rsp_value_out)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/lphm_checker.sv =====
// Port-level checker for the linear probe hash map, bound to the top level.
// Depends on lphm_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module lphm_checker import lphm_pkg::*; (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_ready,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic [2:0]           rsp_status,
   input wire logic [DATA_BITS-1:0] rsp_value_out
);

   // A result word waiting on the consumer must not change.
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_value_out), "result word changed while stalled")

   // Only a found result carries a value.
   `ASSERT_CLK(a_value_zero, clock, reset, rsp_valid && (rsp_status != STS_FOUND) |-> rsp_value_out == '0, "value_out nonzero on a result other than found")

   // Status codes stop at the zero-key code.
   `ASSERT_CLK(a_status_code, clock, reset, rsp_valid |-> rsp_status <= STS_ZERO, "undefined status code")

   // Right after reset no result is shown and the clearing pass holds off requests.
   `ASSERT_CLK_ALL(a_after_reset, clock, $past(reset) |-> !rsp_valid && !req_ready, "activity right after reset")

endmodule

bind linear_probe_hash_map_top lphm_checker u_lphm_checker (.*);

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for linear_probe_hash_map_top: insert and lookup words
// are checked against a behavioral copy of the probed table. Depends on lphm_pkg.
`default_nettype none

module tb_top;
   import lphm_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct {
      status_type            st;
      logic [DATA_BITS-1:0]  val;
   } map_answer_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_action = 1'b0;
   logic [IN_KEY_BITS-1:0] req_key = '0;
   logic [DATA_BITS-1:0]   req_value = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [2:0]             rsp_status;
   logic [DATA_BITS-1:0]   rsp_value_out;

   // Behavioral copy of the table.
   logic [KEY_BITS-1:0]    map_keys [TABLE_SLOTS];
   logic [DATA_BITS-1:0]   map_vals [TABLE_SLOTS];
   int unsigned            map_fill;
   logic [IN_KEY_BITS-1:0] known_keys [$];

   map_answer_type         answers_due [$];
   int unsigned            error_count;
   int unsigned            words_sent;
   int unsigned            results_checked;
   int unsigned            seen_by_status [6];
   int unsigned            quiet_cycles;
   int unsigned            gap_pct;
   int unsigned            stall_pct;

   linear_probe_hash_map_top dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (req_action),
      .req_key       (req_key),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_value_out (rsp_value_out)
   );

   always #6 clock = ~clock;

   function automatic int unsigned home_slot(input logic [KEY_BITS-1:0] k);
      logic [KEY_BITS-1:0] h;
      h = k;
      h = h ^ (h >> 15);
      h = h * KEY_BITS'(64'd2654435761);
      h = h ^ (h >> 13);
      return h[SLOT_BITS-1:0];
   endfunction

   // Applies one request to the table copy and returns the answer it should get.
   function automatic void predict_map(input action_type act,
                                       input logic [IN_KEY_BITS-1:0] raw_key,
                                       input logic [DATA_BITS-1:0] val,
                                       output status_type st,
                                       output logic [DATA_BITS-1:0] vout);
      logic [KEY_BITS-1:0] k;
      int unsigned idx;
      int unsigned steps;
      bit hit;
      bit room;
      bit done;
      k = KEY_BITS'(raw_key);
      vout = '0;
      if (k == '0) begin
         st = STS_ZERO;
      end else begin
         hit = 1'b0;
         room = 1'b0;
         done = 1'b0;
         steps = 0;
         idx = home_slot(k);
         while (!done && steps < TABLE_SLOTS) begin
            if (map_keys[idx] == '0) begin
               room = 1'b1;
               done = 1'b1;
            end else if (map_keys[idx] == k) begin
               hit = 1'b1;
               done = 1'b1;
            end else begin
               idx = (idx + 1) % TABLE_SLOTS;
               steps++;
            end
         end
         if (act == ACT_LOOKUP) begin
            if (hit) begin
               st = STS_FOUND;
               vout = map_vals[idx];
            end else begin
               st = STS_MISS;
            end
         end else if (hit) begin
            st = STS_KEPT;
         end else if ((map_fill + 1) * 4 >= TABLE_SLOTS * 3 || !room) begin
            st = STS_FULL;
         end else begin
            map_keys[idx] = k;
            map_vals[idx] = val;
            map_fill++;
            known_keys.push_back(raw_key);
            st = STS_INSERTED;
         end
      end
   endfunction

   function automatic logic [IN_KEY_BITS-1:0] key_for_slot(input int unsigned slot);
      logic [IN_KEY_BITS-1:0] k;
      k = $urandom();
      while (k == '0 || home_slot(KEY_BITS'(k)) != slot) k = $urandom();
      return k;
   endfunction

   function automatic logic [IN_KEY_BITS-1:0] pick_known();
      if (known_keys.size() == 0) return $urandom();
      return known_keys[$urandom_range(0, known_keys.size() - 1)];
   endfunction

   // Entered just after a falling edge; returns just after the falling edge that
   // follows acceptance, with valid still high so that words can go back to back.
   task automatic send_word(input action_type act, input logic [IN_KEY_BITS-1:0] key,
                            input logic [DATA_BITS-1:0] val, output status_type outcome);
      map_answer_type ans;
      int unsigned pause;
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         pause = $urandom_range(1, 17);
         req_valid <= 1'b0;
         repeat (pause) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= act;
      req_key    <= key;
      req_value  <= val;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      predict_map(act, key, val, ans.st, ans.val);
      answers_due.push_back(ans);
      words_sent++;
      outcome = ans.st;
      @(negedge clock);
   endtask

   // Holds the request side idle until every outstanding result is back.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (answers_due.size() != 0) @(negedge clock);
   endtask

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= 10) $display("ERROR: %s", msg);
   endtask

   always @(posedge clock) begin : result_check
      map_answer_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (answers_due.size() == 0) begin
            report_error($sformatf("result with nothing outstanding: status %0d value %h",
                                   rsp_status, rsp_value_out));
         end else begin
            want = answers_due.pop_front();
            results_checked++;
            seen_by_status[int'(want.st)]++;
            if (rsp_status !== 3'(want.st))
               report_error($sformatf("status: expected %0d (%s), got %0d",
                                      want.st, want.st.name(), rsp_status));
            if (rsp_value_out !== want.val)
               report_error($sformatf("value_out: expected %h, got %h",
                                      want.val, rsp_value_out));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("tb_top: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Result side: random stall bursts while stall_pct is nonzero.
   initial begin : result_pacing
      int unsigned burst;
      forever begin
         @(negedge clock);
         if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            burst = $urandom_range(1, 17);
            rsp_ready <= 1'b0;
            repeat (burst) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   task automatic test_zero_and_extremes();
      status_type st;
      send_word(ACT_LOOKUP, '0, 32'hFFFF_FFFF, st);
      send_word(ACT_INSERT, '0, 32'h1234_5678, st);
      send_word(ACT_LOOKUP, 32'hFFFF_FFFF, '0, st);
      send_word(ACT_INSERT, 32'hFFFF_FFFF, '0, st);
      send_word(ACT_INSERT, 32'h0000_0001, 32'hFFFF_FFFF, st);
      send_word(ACT_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, st);
      send_word(ACT_LOOKUP, 32'h0000_0001, '0, st);
      // The second insert of a key must leave the first value in place.
      send_word(ACT_INSERT, 32'h0000_0001, 32'h5A5A_0F0F, st);
      send_word(ACT_LOOKUP, 32'h0000_0001, '0, st);
      send_word(ACT_INSERT, 32'h8000_0000, 32'hA5A5_A5A5, st);
      send_word(ACT_LOOKUP, 32'h8000_0000, 32'hFFFF_FFFF, st);
      drain_results();
   endtask

   // Keys that share the last slot force the probe to wrap to slot zero.
   task automatic test_probe_wrap();
      status_type st;
      logic [IN_KEY_BITS-1:0] chain [3];
      logic [IN_KEY_BITS-1:0] absent;
      logic [IN_KEY_BITS-1:0] low_key;
      foreach (chain[i]) chain[i] = key_for_slot(TABLE_SLOTS - 1);
      absent = key_for_slot(TABLE_SLOTS - 1);
      low_key = key_for_slot(0);
      foreach (chain[i]) send_word(ACT_INSERT, chain[i], $urandom(), st);
      foreach (chain[i]) send_word(ACT_LOOKUP, chain[i], '0, st);
      send_word(ACT_LOOKUP, absent, '0, st);
      send_word(ACT_INSERT, low_key, $urandom(), st);
      send_word(ACT_LOOKUP, low_key, '0, st);
      drain_results();
   endtask

   task automatic send_random_op();
      status_type st;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 30)
         send_word(ACT_INSERT, $urandom(), $urandom(), st);
      else if (pick < 38)
         send_word(ACT_INSERT, key_for_slot((TABLE_SLOTS - 3 + $urandom_range(0, 3))
                                            % TABLE_SLOTS), $urandom(), st);
      else if (pick < 46)
         send_word(ACT_INSERT, pick_known(), $urandom(), st);
      else if (pick < 76)
         send_word(ACT_LOOKUP, pick_known(), $urandom(), st);
      else if (pick < 92)
         send_word(ACT_LOOKUP, $urandom(), $urandom(), st);
      else
         send_word(action_type'($urandom_range(0, 1)), '0, $urandom(), st);
   endtask

   task automatic test_random_traffic();
      gap_pct = 25;
      stall_pct = 25;
      repeat (150) send_random_op();
      gap_pct = 0;
      stall_pct = 0;
      repeat (150) send_random_op();
      gap_pct = 15;
      stall_pct = 50;
      repeat (150) send_random_op();
      drain_results();
   endtask

   // Grows the table until inserts are refused, then checks behavior at full load.
   task automatic test_fill_to_capacity();
      status_type st;
      gap_pct = 10;
      stall_pct = 20;
      st = STS_INSERTED;
      while (st != STS_FULL) begin
         if ($urandom_range(0, 4) == 0)
            send_word(ACT_LOOKUP, pick_known(), $urandom(), st);
         else
            send_word(ACT_INSERT, $urandom(), $urandom(), st);
      end
      gap_pct = 0;
      stall_pct = 0;
      repeat (4) send_word(ACT_INSERT, $urandom(), $urandom(), st);
      repeat (4) send_word(ACT_INSERT, pick_known(), $urandom(), st);
      repeat (6) send_word(ACT_LOOKUP, pick_known(), $urandom(), st);
      repeat (6) send_word(ACT_LOOKUP, $urandom(), $urandom(), st);
      send_word(ACT_INSERT, '0, $urandom(), st);
      send_word(ACT_LOOKUP, '0, $urandom(), st);
   endtask

   initial begin
      foreach (map_keys[i]) begin
         map_keys[i] = '0;
         map_vals[i] = '0;
      end
      map_fill = 0;
      error_count = 0;
      words_sent = 0;
      results_checked = 0;
      foreach (seen_by_status[i]) seen_by_status[i] = 0;
      gap_pct = 0;
      stall_pct = 10;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      test_zero_and_extremes();
      test_probe_wrap();
      test_random_traffic();
      test_fill_to_capacity();

      req_valid <= 1'b0;
      while (answers_due.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);

      $display("summary: %0d words sent, %0d results checked, table peaked at %0d entries",
               words_sent, results_checked, map_fill);
      $display("summary: inserted %0d kept %0d full %0d found %0d missed %0d zero key %0d",
               seen_by_status[0], seen_by_status[1], seen_by_status[2],
               seen_by_status[3], seen_by_status[4], seen_by_status[5]);
      if (error_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("%0d mismatches", error_count);
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

`default_nettype wire
